// File: hw/rtl/tsp_pkg.sv
// shared widths, codes and types for the trapezoidal speed profile block
// no dependencies; imported by tsp_ctrl, tsp_div and trapezoidal_speed_profile
package tsp_pkg;

    // item field widths
    localparam int SPEED_W   = 20;   // measured speed and speed command, signed
    localparam int DIST_W    = 24;   // goal distance and reach offset, signed
    localparam int STOP_W    = 23;   // stop distance, unsigned
    localparam int CFG_SPD_W = 19;   // arrival speed and speed limit
    localparam int CFG_ACC_W = 18;   // accel and decel limits
    localparam int CFG_W     = 19;   // config write data
    localparam int DV2_W     = 2 * CFG_SPD_W;   // square of a positive speed excess
    localparam int DEN_W     = CFG_ACC_W + 1;   // 2 * decel

    localparam logic [STOP_W-1:0] STOP_MAX = {STOP_W{1'b1}};

    localparam int TSP_TICKS_DEFAULT = 10;

    // register reset values
    localparam logic [CFG_SPD_W-1:0] ARRIVAL_RST = CFG_SPD_W'(0);
    localparam logic [CFG_SPD_W-1:0] LIMIT_RST   = CFG_SPD_W'(32768);
    localparam logic [CFG_ACC_W-1:0] ACCEL_RST   = CFG_ACC_W'(22938);
    localparam logic [CFG_ACC_W-1:0] DECEL_RST   = CFG_ACC_W'(22938);

    typedef enum logic [1:0] {
        CFG_ARRIVAL = 2'd0,
        CFG_LIMIT   = 2'd1,
        CFG_ACCEL   = 2'd2,
        CFG_DECEL   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_DECEL  = 2'd0,
        PH_BRAKE  = 2'd1,
        PH_ACCEL  = 2'd2,
        PH_CRUISE = 2'd3
    } t_phase;

    // decision pipeline to stop distance divider
    typedef struct packed {
        logic [DV2_W-1:0]          dv2;   // squared speed excess, zero if none
        logic                      clr;   // no speed excess: stop distance is zero
        logic signed [SPEED_W-1:0] cmd;
        t_phase                    phase;
    } t_ctrl_res;

    // divider to output register
    typedef struct packed {
        logic signed [SPEED_W-1:0] cmd;
        t_phase                    phase;
        logic [STOP_W-1:0]         stop;
    } t_prof_res;

endpackage

// File: hw/rtl/tsp_ctrl.sv
// phase decision pipeline: products, exact compares, steps, clamp (six stages)
// depends on tsp_pkg
module tsp_ctrl #(
    parameter int TICKS_PER_SECOND = tsp_pkg::TSP_TICKS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic signed [tsp_pkg::SPEED_W-1:0]   i_speed,
    input  logic signed [tsp_pkg::DIST_W-1:0]    i_goal,
    input  logic signed [tsp_pkg::DIST_W-1:0]    i_reach,
    input  logic [tsp_pkg::CFG_SPD_W-1:0]        i_arrival,
    input  logic [tsp_pkg::CFG_SPD_W-1:0]        i_limit,
    input  logic [tsp_pkg::CFG_ACC_W-1:0]        i_accel,
    input  logic [tsp_pkg::CFG_ACC_W-1:0]        i_decel,
    output logic                                 o_vld,
    output tsp_pkg::t_ctrl_res                   o_res
);
    import tsp_pkg::*;

    localparam int RW     = $clog2(TICKS_PER_SECOND + 1);
    localparam int R4W    = $clog2(4 * TICKS_PER_SECOND + 1);
    localparam int RRW    = $clog2(TICKS_PER_SECOND * TICKS_PER_SECOND + 1);
    localparam int R2W    = $clog2(2 * TICKS_PER_SECOND * TICKS_PER_SECOND + 1);
    localparam int L_W    = DIST_W + 1;
    localparam int PL2_W  = L_W + R2W + 1;
    localparam int PV4_W  = SPEED_W + R4W + 1;
    localparam int LR_W   = L_W + RW + 1;
    localparam int PDL_W  = L_W + DEN_W + 1;
    localparam int M_W    = PL2_W + 2;
    localparam int DM_W   = M_W + CFG_ACC_W + 1;
    localparam int DV2R_W = DV2_W + RRW;
    localparam int STEP_W = CFG_ACC_W;
    localparam int QR_W   = STEP_W + RW;
    localparam int SH     = CFG_ACC_W + RW;
    localparam int RCP_W  = SH + 1;
    localparam int CMDR_W = SPEED_W + 1;
    localparam int SUM_W  = CFG_ACC_W + 1;

    localparam logic [RCP_W-1:0]  RCP  = RCP_W'((longint'(1) << SH) / TICKS_PER_SECOND);
    localparam logic signed [R2W:0] K2RR =
        (R2W + 1)'(2 * TICKS_PER_SECOND * TICKS_PER_SECOND);
    localparam logic signed [R4W:0] K4R  = (R4W + 1)'(4 * TICKS_PER_SECOND);
    localparam logic signed [RW:0]  KR   = (RW + 1)'(TICKS_PER_SECOND);
    localparam logic [RRW-1:0]      KRR  = RRW'(TICKS_PER_SECOND * TICKS_PER_SECOND);
    localparam logic [RW-1:0]       KRU  = RW'(TICKS_PER_SECOND);
    localparam logic [QR_W-1:0]     KRQ  = QR_W'(TICKS_PER_SECOND);

    // ---------------- stage a: distance left and speed excess
    logic signed [SPEED_W:0]   a_dv;
    logic signed [L_W-1:0]     a_l;
    logic                      a_dvpos;

    logic                      r_a_vld;
    logic signed [SPEED_W-1:0] r_a_v;
    logic signed [L_W-1:0]     r_a_l;
    logic [CFG_SPD_W-1:0]      r_a_dvm;
    logic                      r_a_dvpos;

    always_comb begin
        a_dv = $signed({i_speed[SPEED_W-1], i_speed})
             - $signed({{(SPEED_W + 1 - CFG_SPD_W){1'b0}}, i_arrival});
        a_dvpos = !a_dv[SPEED_W] && (a_dv != '0);
        a_l = $signed({i_goal[DIST_W-1], i_goal}) - $signed({i_reach[DIST_W-1], i_reach});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
        r_a_v     <= i_speed;
        r_a_l     <= a_l;
        r_a_dvm   <= a_dvpos ? a_dv[CFG_SPD_W-1:0] : '0;
        r_a_dvpos <= a_dvpos;
    end

    // ---------------- stage b: products
    logic [DV2_W-1:0]             b_dv2;
    logic signed [PL2_W-1:0]      b_pl2;
    logic signed [PV4_W-1:0]      b_pv4;
    logic signed [LR_W-1:0]       b_lr;
    logic signed [PDL_W-1:0]      b_pdl;
    logic [CFG_ACC_W+RCP_W-1:0]   b_dq_full;
    logic [CFG_ACC_W+RCP_W-1:0]   b_aq_full;

    logic                      r_b_vld;
    logic signed [SPEED_W-1:0] r_b_v;
    logic                      r_b_lneg;
    logic                      r_b_dvpos;
    logic [DV2_W-1:0]          r_b_dv2;
    logic signed [PL2_W-1:0]   r_b_pl2;
    logic signed [PV4_W-1:0]   r_b_pv4;
    logic signed [LR_W-1:0]    r_b_lr;
    logic signed [PDL_W-1:0]   r_b_pdl;
    logic [STEP_W-1:0]         r_b_dq;
    logic [STEP_W-1:0]         r_b_aq;
    logic [SUM_W-1:0]          r_b_sum;

    always_comb begin
        b_dv2     = r_a_dvm * r_a_dvm;
        b_pl2     = r_a_l * K2RR;
        b_pv4     = r_a_v * K4R;
        b_lr      = r_a_l * KR;
        b_pdl     = r_a_l * $signed({1'b0, i_decel, 1'b0});
        // reciprocal estimate of limit / ticks, low by at most one
        b_dq_full = i_decel * RCP;
        b_aq_full = i_accel * RCP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_v     <= r_a_v;
        r_b_lneg  <= r_a_l[L_W-1];
        r_b_dvpos <= r_a_dvpos;
        r_b_dv2   <= b_dv2;
        r_b_pl2   <= b_pl2;
        r_b_pv4   <= b_pv4;
        r_b_lr    <= b_lr;
        r_b_pdl   <= b_pdl;
        r_b_dq    <= b_dq_full[SH +: STEP_W];
        r_b_aq    <= b_aq_full[SH +: STEP_W];
        r_b_sum   <= {1'b0, i_accel} + {1'b0, i_decel};
    end

    // ---------------- stage c: margin, braking test, step correction
    logic signed [M_W-1:0] c_m;
    logic                  c_emrg;
    logic                  c_decel;
    logic [DV2R_W-1:0]     c_dv2r;
    logic [QR_W-1:0]       c_dqr;
    logic [QR_W-1:0]       c_aqr;
    logic [QR_W-1:0]       c_drem;
    logic [QR_W-1:0]       c_arem;

    logic                      r_c_vld;
    logic signed [SPEED_W-1:0] r_c_v;
    logic                      r_c_dvpos;
    logic [DV2_W-1:0]          r_c_dv2;
    logic signed [M_W-1:0]     r_c_m;
    logic                      r_c_emrg;
    logic                      r_c_decel;
    logic [DV2R_W-1:0]         r_c_dv2r;
    logic [STEP_W-1:0]         r_c_dstep;
    logic [STEP_W-1:0]         r_c_astep;

    always_comb begin
        // 2 r^2 l - (4 v r + accel + decel)
        c_m = M_W'(r_b_pl2) - M_W'(r_b_pv4)
            - $signed({{(M_W - SUM_W){1'b0}}, r_b_sum});
        c_emrg  = r_b_lr < LR_W'(r_b_v);
        c_decel = r_b_dvpos
                ? ((i_decel == '0) ||
                   (r_b_pdl < $signed({{(PDL_W - DV2_W){1'b0}}, r_b_dv2})))
                : r_b_lneg;
        c_dv2r  = r_b_dv2 * KRR;
        c_dqr   = r_b_dq * KRU;
        c_aqr   = r_b_aq * KRU;
        c_drem  = {{RW{1'b0}}, i_decel} - c_dqr;
        c_arem  = {{RW{1'b0}}, i_accel} - c_aqr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_v     <= r_b_v;
        r_c_dvpos <= r_b_dvpos;
        r_c_dv2   <= r_b_dv2;
        r_c_m     <= c_m;
        r_c_emrg  <= c_emrg;
        r_c_decel <= c_decel;
        r_c_dv2r  <= c_dv2r;
        r_c_dstep <= r_b_dq + STEP_W'(c_drem >= KRQ);
        r_c_astep <= r_b_aq + STEP_W'(c_arem >= KRQ);
    end

    // ---------------- stage d: decel times margin
    logic signed [DM_W-1:0] d_dm;

    logic                      r_d_vld;
    logic signed [SPEED_W-1:0] r_d_v;
    logic                      r_d_dvpos;
    logic [DV2_W-1:0]          r_d_dv2;
    logic signed [DM_W-1:0]    r_d_dm;
    logic                      r_d_mpos;
    logic                      r_d_emrg;
    logic                      r_d_decel;
    logic [DV2R_W-1:0]         r_d_dv2r;
    logic [STEP_W-1:0]         r_d_dstep;
    logic [STEP_W-1:0]         r_d_astep;

    assign d_dm = r_c_m * $signed({1'b0, i_decel});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_v     <= r_c_v;
        r_d_dvpos <= r_c_dvpos;
        r_d_dv2   <= r_c_dv2;
        r_d_dm    <= d_dm;
        r_d_mpos  <= !r_c_m[M_W-1] && (r_c_m != '0);
        r_d_emrg  <= r_c_emrg;
        r_d_decel <= r_c_decel;
        r_d_dv2r  <= r_c_dv2r;
        r_d_dstep <= r_c_dstep;
        r_d_astep <= r_c_astep;
    end

    // ---------------- stage e: phase pick and raw command
    logic                     e_accel;
    logic signed [CMDR_W-1:0] e_v;
    logic signed [CMDR_W-1:0] e_raw;
    t_phase                   e_phase;

    logic                     r_e_vld;
    logic signed [CMDR_W-1:0] r_e_raw;
    t_phase                   r_e_phase;
    logic                     r_e_dvpos;
    logic [DV2_W-1:0]         r_e_dv2;

    always_comb begin
        e_accel = r_d_dvpos
                ? ((i_decel != '0) &&
                   (r_d_dm > $signed({{(DM_W - DV2R_W){1'b0}}, r_d_dv2r})))
                : r_d_mpos;
        e_v = $signed({r_d_v[SPEED_W-1], r_d_v});
        if (r_d_decel) begin
            e_raw   = e_v - $signed({{(CMDR_W - STEP_W){1'b0}}, r_d_dstep});
            e_phase = PH_DECEL;
        end else if (r_d_emrg) begin
            e_raw   = '0;
            e_phase = PH_BRAKE;
        end else if (e_accel) begin
            e_raw   = e_v + $signed({{(CMDR_W - STEP_W){1'b0}}, r_d_astep});
            e_phase = PH_ACCEL;
        end else begin
            e_raw   = e_v;
            e_phase = PH_CRUISE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_raw   <= e_raw;
        r_e_phase <= e_phase;
        r_e_dvpos <= r_d_dvpos;
        r_e_dv2   <= r_d_dv2;
    end

    // ---------------- stage f: clamp to the speed limit
    logic signed [CMDR_W-1:0] f_lim;
    logic signed [CMDR_W-1:0] f_cmd;
    t_ctrl_res                f_res;

    logic      r_f_vld;
    t_ctrl_res r_f_res;

    always_comb begin
        f_lim = $signed({{(CMDR_W - CFG_SPD_W){1'b0}}, i_limit});
        if (r_e_raw < -f_lim) begin
            f_cmd = -f_lim;
        end else if (r_e_raw > f_lim) begin
            f_cmd = f_lim;
        end else begin
            f_cmd = r_e_raw;
        end
        f_res.dv2   = r_e_dv2;
        f_res.clr   = !r_e_dvpos;
        f_res.cmd   = f_cmd[SPEED_W-1:0];
        f_res.phase = r_e_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
        r_f_res <= f_res;
    end

    assign o_vld = r_f_vld;
    assign o_res = r_f_res;

endmodule

// File: hw/rtl/tsp_div.sv
// stop distance divider: squared excess over twice the decel, one quotient bit a stage
// depends on tsp_pkg; command and phase ride along with each item
module tsp_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  tsp_pkg::t_ctrl_res             i_res,
    input  logic [tsp_pkg::CFG_ACC_W-1:0]  i_decel,
    output logic                           o_vld,
    output tsp_pkg::t_prof_res             o_res
);
    import tsp_pkg::*;

    localparam int Q_W  = STOP_W;
    localparam int HI_W = DV2_W - STOP_W;

    typedef struct packed {
        logic signed [SPEED_W-1:0] cmd;
        t_phase                    phase;
        logic                      sat;
        logic                      clr;
    } t_div_side;

    logic [DEN_W-1:0] den;
    logic [HI_W-1:0]  hi;

    logic             r_vld  [0:Q_W];
    logic [DEN_W-1:0] r_rem  [0:Q_W];
    logic [Q_W-1:0]   r_work [0:Q_W];
    t_div_side        r_side [0:Q_W];

    assign den = {i_decel, 1'b0};
    assign hi  = i_res.dv2[DV2_W-1:STOP_W];

    // entry: quotient at or above 2^23 saturates, zero decel too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rem[0]        <= {{(DEN_W - HI_W){1'b0}}, hi};
        r_work[0]       <= i_res.dv2[STOP_W-1:0];
        r_side[0].cmd   <= i_res.cmd;
        r_side[0].phase <= i_res.phase;
        r_side[0].sat   <= !i_res.clr && ({{(DEN_W - HI_W){1'b0}}, hi} >= den);
        r_side[0].clr   <= i_res.clr;
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb begin
            trial = {r_rem[k-1], r_work[k-1][Q_W-1]};
            diff  = trial - {1'b0, den};
            ge    = trial >= {1'b0, den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_rem[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_work[k] <= {r_work[k-1][Q_W-2:0], ge};
            r_side[k] <= r_side[k-1];
        end
    end

    always_comb begin
        o_res.cmd   = r_side[Q_W].cmd;
        o_res.phase = r_side[Q_W].phase;
        if (r_side[Q_W].sat) begin
            o_res.stop = STOP_MAX;
        end else if (r_side[Q_W].clr) begin
            o_res.stop = '0;
        end else begin
            o_res.stop = r_work[Q_W];
        end
    end

    assign o_vld = r_vld[Q_W];

endmodule

// File: hw/rtl/trapezoidal_speed_profile.sv
// top level of the trapezoidal speed profile: config registers, pipeline, output register
// depends on tsp_pkg, tsp_ctrl and tsp_div

// one item per clock, every clock: start is taken whenever it is high (busy stays
// low) and each item gives exactly one result, shown for a single cycle with
// o_strobe. each item passes through the six stage decision pipeline (products,
// exact cross-multiplied compares, clamp), the 24 stage stop distance divider
// (an entry stage, then one quotient bit per stage) and the output register.
// results leave in the order items came in and the receiver has no way to hold
// them off. config writes land at once; write only while no item is in flight
module trapezoidal_speed_profile #(
    parameter int TICKS_PER_SECOND = tsp_pkg::TSP_TICKS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item handshake
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tsp_pkg::SPEED_W-1:0]  i_measured_speed,
    input  logic signed [tsp_pkg::DIST_W-1:0]   i_goal_distance,
    input  logic signed [tsp_pkg::DIST_W-1:0]   i_reach_offset,
    // config write port
    input  logic                                i_cfg_we,
    input  tsp_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [tsp_pkg::CFG_W-1:0]           i_cfg_wdata,
    // results
    output logic                                o_strobe,
    output logic signed [tsp_pkg::SPEED_W-1:0]  o_speed_command,
    output logic [1:0]                          o_profile_phase,
    output logic [tsp_pkg::STOP_W-1:0]          o_stop_distance
);
    import tsp_pkg::*;

    // config registers
    logic [CFG_SPD_W-1:0] r_arrival;
    logic [CFG_SPD_W-1:0] r_limit;
    logic [CFG_ACC_W-1:0] r_accel;
    logic [CFG_ACC_W-1:0] r_decel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrival <= ARRIVAL_RST;
            r_limit   <= LIMIT_RST;
            r_accel   <= ACCEL_RST;
            r_decel   <= DECEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ARRIVAL: r_arrival <= i_cfg_wdata[CFG_SPD_W-1:0];
                CFG_LIMIT:   r_limit   <= i_cfg_wdata[CFG_SPD_W-1:0];
                CFG_ACCEL:   r_accel   <= i_cfg_wdata[CFG_ACC_W-1:0];
                CFG_DECEL:   r_decel   <= i_cfg_wdata[CFG_ACC_W-1:0];
                default:     r_arrival <= r_arrival;
            endcase
        end
    end

    // fully pipelined, never stalls
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // phase decision
    logic      ctrl_vld;
    t_ctrl_res ctrl_res;

    tsp_ctrl #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (accept),
        .i_speed   (i_measured_speed),
        .i_goal    (i_goal_distance),
        .i_reach   (i_reach_offset),
        .i_arrival (r_arrival),
        .i_limit   (r_limit),
        .i_accel   (r_accel),
        .i_decel   (r_decel),
        .o_vld     (ctrl_vld),
        .o_res     (ctrl_res)
    );

    // stop distance, with command and phase carried alongside
    logic      div_vld;
    t_prof_res div_res;

    tsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (ctrl_vld),
        .i_res   (ctrl_res),
        .i_decel (r_decel),
        .o_vld   (div_vld),
        .o_res   (div_res)
    );

    // output register: one cycle strobe per item
    logic      r_strobe;
    t_prof_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= div_vld;
        end
        r_out <= div_res;
    end

    assign o_strobe        = r_strobe;
    assign o_speed_command = r_out.cmd;
    assign o_profile_phase = r_out.phase;
    assign o_stop_distance = r_out.stop;

endmodule

// File: tb/sv/tsp_profile_checker.sv
`timescale 1ns / 1ps
// result checker for the trapezoidal speed profile: mirrors config writes, predicts each item
// and compares the strobed results in order; depends on tsp_pkg only
module tsp_profile_checker #(
    parameter int TICKS = tsp_pkg::TSP_TICKS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic signed [tsp_pkg::SPEED_W-1:0]  i_measured_speed,
    input  logic signed [tsp_pkg::DIST_W-1:0]   i_goal_distance,
    input  logic signed [tsp_pkg::DIST_W-1:0]   i_reach_offset,
    input  logic                                i_cfg_we,
    input  tsp_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [tsp_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_strobe,
    input  logic signed [tsp_pkg::SPEED_W-1:0]  i_speed_command,
    input  logic [1:0]                          i_profile_phase,
    input  logic [tsp_pkg::STOP_W-1:0]          i_stop_distance,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import tsp_pkg::*;

    typedef struct {
        logic signed [SPEED_W-1:0] cmd;
        t_phase                    phase;
        logic [STOP_W-1:0]         stop;
    } t_motion_order;

    logic [CFG_SPD_W-1:0] arrival_q;
    logic [CFG_SPD_W-1:0] limit_q;
    logic [CFG_ACC_W-1:0] accel_q;
    logic [CFG_ACC_W-1:0] decel_q;

    t_motion_order orders_due[$];
    int            fails = 0;

    assign o_fail_count = fails;

    // exact integer form of the profile decision, all in 64 bit
    function automatic t_motion_order plan_motion(input logic signed [SPEED_W-1:0] spd,
                                                  input logic signed [DIST_W-1:0]  goal,
                                                  input logic signed [DIST_W-1:0]  reach);
        longint        rt, v, lead, vf, acl, dcl, lim, dv, dv2, xnum, stopd, cmd;
        bit            slow, speed_up;
        t_motion_order res;
        rt   = longint'(TICKS);
        v    = longint'(spd);
        lead = longint'(goal) - longint'(reach);
        vf   = longint'(arrival_q);
        acl  = longint'(accel_q);
        dcl  = longint'(decel_q);
        lim  = longint'(limit_q);
        dv   = v - vf;
        dv2  = (dv > 0) ? dv * dv : 0;
        xnum = 4 * v * rt + acl + dcl;
        if (dv > 0) begin
            if (dcl == 0) begin
                // no braking at all: the stop distance is unbounded
                stopd    = longint'(STOP_MAX);
                slow     = 1'b1;
                speed_up = 1'b0;
            end else begin
                stopd    = dv2 / (2 * dcl);
                if (stopd > longint'(STOP_MAX)) stopd = longint'(STOP_MAX);
                slow     = (2 * dcl * lead) < dv2;
                speed_up = (2 * dcl * rt * rt * lead) > (dv2 * rt * rt + dcl * xnum);
            end
        end else begin
            stopd    = 0;
            slow     = lead < 0;
            speed_up = (2 * rt * rt * lead) > xnum;
        end
        if (slow) begin
            cmd       = v - dcl / rt;
            res.phase = PH_DECEL;
        end else if (lead * rt < v) begin
            cmd       = 0;
            res.phase = PH_BRAKE;
        end else if (speed_up) begin
            cmd       = v + acl / rt;
            res.phase = PH_ACCEL;
        end else begin
            cmd       = v;
            res.phase = PH_CRUISE;
        end
        if (cmd < -lim) cmd = -lim;
        if (cmd > lim) cmd = lim;
        res.cmd  = cmd[SPEED_W-1:0];
        res.stop = stopd[STOP_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_motion_order due;
        if (!i_rst_n) begin
            arrival_q <= ARRIVAL_RST;
            limit_q   <= LIMIT_RST;
            accel_q   <= ACCEL_RST;
            decel_q   <= DECEL_RST;
            orders_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ARRIVAL: arrival_q <= i_cfg_wdata[CFG_SPD_W-1:0];
                    CFG_LIMIT:   limit_q   <= i_cfg_wdata[CFG_SPD_W-1:0];
                    CFG_ACCEL:   accel_q   <= i_cfg_wdata[CFG_ACC_W-1:0];
                    CFG_DECEL:   decel_q   <= i_cfg_wdata[CFG_ACC_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                orders_due.push_back(plan_motion(i_measured_speed, i_goal_distance,
                                                 i_reach_offset));
            if (i_strobe) begin
                if (orders_due.size() == 0) begin
                    $error("result with no item outstanding: cmd %0d phase %0d stop %0d",
                           i_speed_command, i_profile_phase, i_stop_distance);
                    fails++;
                end else begin
                    due = orders_due.pop_front();
                    if (i_speed_command !== due.cmd) begin
                        $error("speed_command: expected %0d, got %0d", due.cmd,
                               i_speed_command);
                        fails++;
                    end
                    if (i_profile_phase !== due.phase) begin
                        $error("profile_phase: expected %0d, got %0d", due.phase,
                               i_profile_phase);
                        fails++;
                    end
                    if (i_stop_distance !== due.stop) begin
                        $error("stop_distance: expected %0d, got %0d", due.stop,
                               i_stop_distance);
                        fails++;
                    end
                end
            end
            o_pending <= orders_due.size();
        end
    end

endmodule

// File: tb/sv/tb_trapezoidal_speed_profile.sv
`timescale 1ns / 1ps
// testbench top for trapezoidal_speed_profile: clock, reset, config phases and item stimulus
// depends on tsp_pkg, the block under test and tsp_profile_checker
module tb_trapezoidal_speed_profile;
    import tsp_pkg::*;

    localparam int TICKS        = TSP_TICKS_DEFAULT;
    localparam int N_SETTINGS   = 5;
    localparam int N_PER_SETTING = 96;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;   // longer than an item takes to pass through the block

    localparam longint SPD_MIN  = -(longint'(1) << (SPEED_W - 1));
    localparam longint SPD_MAX  = (longint'(1) << (SPEED_W - 1)) - 1;
    localparam longint DIST_MIN = -(longint'(1) << (DIST_W - 1));
    localparam longint DIST_MAX = (longint'(1) << (DIST_W - 1)) - 1;

    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      start            = 1'b0;
    logic                      busy;
    logic signed [SPEED_W-1:0] i_measured_speed = '0;
    logic signed [DIST_W-1:0]  i_goal_distance  = '0;
    logic signed [DIST_W-1:0]  i_reach_offset   = '0;
    logic                      i_cfg_we         = 1'b0;
    t_cfg_idx                  i_cfg_idx        = CFG_ARRIVAL;
    logic [CFG_W-1:0]          i_cfg_wdata      = '0;
    logic                      o_strobe;
    logic signed [SPEED_W-1:0] o_speed_command;
    logic [1:0]                o_profile_phase;
    logic [STOP_W-1:0]         o_stop_distance;

    int fail_count;
    int pending;

    // copy of the written arrival, accel and decel settings, only used to aim items near the phase boundaries
    longint aim_arrival = longint'(ARRIVAL_RST);
    longint aim_accel   = longint'(ACCEL_RST);
    longint aim_decel   = longint'(DECEL_RST);

    // items left in the current run of back-to-back starts
    int burst_left = 0;

    always #5 i_clk = ~i_clk;

    trapezoidal_speed_profile #(
        .TICKS_PER_SECOND(TICKS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_measured_speed(i_measured_speed),
        .i_goal_distance (i_goal_distance),
        .i_reach_offset  (i_reach_offset),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_speed_command (o_speed_command),
        .o_profile_phase (o_profile_phase),
        .o_stop_distance (o_stop_distance)
    );

    tsp_profile_checker #(
        .TICKS(TICKS)
    ) u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_measured_speed(i_measured_speed),
        .i_goal_distance (i_goal_distance),
        .i_reach_offset  (i_reach_offset),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_strobe        (o_strobe),
        .i_speed_command (o_speed_command),
        .i_profile_phase (o_profile_phase),
        .i_stop_distance (o_stop_distance),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // gap after an item: mostly none or short, now and then long, plus bursts with none
    function automatic int idle_len();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // present one item, hold it until taken, then maybe idle a while
    // start stays high across back-to-back items so it is never lowered and raised in one step
    task automatic issue_item(input logic signed [SPEED_W-1:0] spd,
                              input logic signed [DIST_W-1:0]  goal,
                              input logic signed [DIST_W-1:0]  reach);
        int gap;
        start            <= 1'b1;
        i_measured_speed <= spd;
        i_goal_distance  <= goal;
        i_reach_offset   <= reach;
        do @(posedge i_clk); while (busy !== 1'b0);
        gap = idle_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop start and wait for every outstanding result; each item gives one, so
    // nothing is left working once the count is zero
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input longint val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[CFG_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_ARRIVAL: aim_arrival = val & ((longint'(1) << CFG_SPD_W) - 1);
            CFG_ACCEL:   aim_accel   = val & ((longint'(1) << CFG_ACC_W) - 1);
            CFG_DECEL:   aim_decel   = val & ((longint'(1) << CFG_ACC_W) - 1);
            default: ;
        endcase
    endtask

    // all four registers, back to back, only while the block is idle
    task automatic load_setting(input longint arrival, input longint limit,
                                input longint accel, input longint decel);
        settle();
        write_reg(CFG_ARRIVAL, arrival);
        write_reg(CFG_LIMIT, limit);
        write_reg(CFG_ACCEL, accel);
        write_reg(CFG_DECEL, decel);
        i_cfg_we <= 1'b0;
    endtask

    // one random item: some with every field fully random, most aimed so that the
    // lead distance lands around the stop distance or the brake threshold
    task automatic random_item();
        longint v, dv, stop_est, span, lead, reach, goal;
        int     pick;
        if ($urandom_range(0, 4) == 0) begin
            issue_item(SPEED_W'($urandom), DIST_W'($urandom), DIST_W'($urandom));
        end else begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: v = aim_arrival + longint'($urandom_range(0, 400)) - 200;
                1: v = longint'($urandom_range(0, 1 << $urandom_range(4, 19)));
                2: v = -longint'($urandom_range(0, 1 << $urandom_range(4, 19)));
                default: v = aim_arrival + longint'($urandom_range(0, 1 << $urandom_range(4, 19)));
            endcase
            if (v < SPD_MIN) v = SPD_MIN;
            if (v > SPD_MAX) v = SPD_MAX;
            dv = v - aim_arrival;
            if (dv <= 0) stop_est = 0;
            else if (aim_decel == 0) stop_est = DIST_MAX;
            else stop_est = dv * dv / (2 * aim_decel);
            // width of the cruise band, plus some room on both sides
            span = ((v < 0) ? -v : v) * 2 / TICKS
                   + (aim_accel + aim_decel) / (2 * TICKS * TICKS) + 4;
            if ($urandom_range(0, 7) == 0)
                lead = v / TICKS + longint'($urandom_range(0, 20)) - 10;
            else
                lead = stop_est - span + longint'($urandom_range(0, 3 * span));
            if (lead < DIST_MIN) lead = DIST_MIN;
            if (lead > DIST_MAX) lead = DIST_MAX;
            reach = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            goal  = lead + reach;
            if (goal < DIST_MIN || goal > DIST_MAX) begin
                goal  = lead;
                reach = 0;
            end
            issue_item(v[SPEED_W-1:0], goal[DIST_W-1:0], reach[DIST_W-1:0]);
        end
    endtask

    initial begin
        int drain;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items at the reset settings (arrival 0, limit 32768, both rates 22938)
        issue_item(524287, 8388607, -8388608);     // field extremes, accelerate then clamp
        issue_item(-524288, -8388608, 8388607);    // opposite extremes, decelerate then clamp
        issue_item(0, 0, 0);                       // at rest on the goal: cruise
        issue_item(32768, 23405, 0);               // last lead short of the stop distance: decelerate
        issue_item(32768, 23406, 0);               // just past it: cruise band
        issue_item(32768, 40000, 0);               // well past it: accelerate
        issue_item(1000, 50, 0);                   // too close for the speed: emergency brake
        issue_item(1000, 99, 0);                   // last lead that still brakes
        issue_item(1000, 100, 0);                  // first lead that does not
        issue_item(0, 1000, 0);                    // start from rest
        issue_item(10000, 3000, 0);                // inside the cruise band
        issue_item(-5000, 10, 0);                  // reversing with the goal ahead
        issue_item(-524288, 0, 0);                 // most negative speed, on the goal
        issue_item(0, -1, 0);                      // goal just behind
        issue_item(0, 8388607, 8388607);           // offset cancels the distance
        issue_item(0, -8388608, -8388608);
        issue_item(200000, 100, -100);             // fast and near: decelerate, speed above limit
        issue_item(-1, 5, 10);                     // tiny negative lead and speed

        // random items over several settings, extremes first; the zero setting covers
        // zero speed limit, zero accel and unbounded stop distance at once
        for (int s = 0; s < N_SETTINGS; s++) begin
            case (s)
                0: load_setting(524287, 524287, 262143, 262143);
                1: load_setting(0, 0, 0, 0);
                2: load_setting(longint'($urandom_range(0, 65535)),
                                longint'($urandom_range(0, 524287)), 1, 1);
                3: load_setting(longint'($urandom_range(0, 524287)),
                                longint'($urandom_range(0, 524287)),
                                longint'($urandom_range(0, 262143)),
                                longint'($urandom_range(0, 262143)));
                default: load_setting(longint'($urandom_range(0, 32767)),
                                      longint'($urandom_range(0, 524287)),
                                      longint'($urandom_range(1, 262143)), 0);
            endcase
            for (int n = 0; n < N_PER_SETTING; n++)
                random_item();
        end

        // drain: wait for the last results with a bound, then let the pipe run empty
        start <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $error("%0d results never arrived", pending);

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
